/* sv/jsof_pkg.sv */
// shared types and constants for the json object stream framer
// no dependencies; imported by jsof_step and json_object_stream_framer
package jsof_pkg;

  localparam int DEPTH_BITS = 8;
  localparam int COUNT_BITS = 12;
  localparam int MAXP_W     = 12;
  localparam int BYTE_W     = 8;
  localparam int NEST_W     = 8;
  localparam int CMP_W      = ((COUNT_BITS > MAXP_W) ? COUNT_BITS : MAXP_W) + 1;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // register index taken from paddr[2]
  localparam logic REG_MAX_PENDING = 1'b0;

  localparam logic [MAXP_W-1:0] MAX_PENDING_RESET = MAXP_W'(1536);

  localparam logic [BYTE_W-1:0] CH_OPEN   = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_CLOSE  = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;

  typedef struct packed {
    logic                  active;
    logic [DEPTH_BITS-1:0] brace_depth;
    logic                  quoted;
    logic                  prev_backslash;
    logic [COUNT_BITS-1:0] pending_count;
  } frame_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    logic              in_object;
    logic              object_start;
    logic              object_end;
    logic [NEST_W-1:0] nest_level;
    logic              dropped;
  } frame_result_t;

endpackage

/* sv/jsof_step.sv */
// per-byte framing logic: next frame state and result for one byte
// depends on jsof_pkg
module jsof_step
  import jsof_pkg::*;
(
  input  frame_state_t        state,
  input  logic [BYTE_W-1:0]   data_byte,
  input  logic [MAXP_W-1:0]   max_pending,
  output frame_state_t        state_next,
  output frame_result_t       result
);

  logic [COUNT_BITS:0]   count_inc;
  logic                  over_limit;
  logic                  depth_full;
  logic [DEPTH_BITS-1:0] depth_dec;
  frame_state_t          cleared;

  assign count_inc  = {1'b0, state.pending_count} + (COUNT_BITS+1)'(1);
  assign over_limit = (CMP_W'(count_inc) > CMP_W'(max_pending)) || count_inc[COUNT_BITS];
  assign depth_full = &state.brace_depth;
  assign depth_dec  = state.brace_depth - DEPTH_BITS'(1);
  assign cleared    = '0;

  always_comb begin
    state_next                 = state;
    state_next.pending_count   = count_inc[COUNT_BITS-1:0];
    result.byte_out            = data_byte;
    result.in_object           = 1'b0;
    result.object_start        = 1'b0;
    result.object_end          = 1'b0;
    result.dropped             = 1'b0;

    if (over_limit) begin
      state_next     = cleared;
      result.dropped = 1'b1;
    end else if (!state.active) begin
      if (data_byte == CH_OPEN) begin
        state_next.active         = 1'b1;
        state_next.brace_depth    = DEPTH_BITS'(1);
        state_next.quoted         = 1'b0;
        state_next.prev_backslash = 1'b0;
        result.in_object          = 1'b1;
        result.object_start       = 1'b1;
      end
    end else begin
      result.in_object = 1'b1;
      if (state.quoted) begin
        // the byte after a backslash is taken literally
        if (state.prev_backslash) begin
          state_next.prev_backslash = 1'b0;
        end else if (data_byte == CH_BSLASH) begin
          state_next.prev_backslash = 1'b1;
        end else if (data_byte == CH_QUOTE) begin
          state_next.quoted = 1'b0;
        end
      end else if (data_byte == CH_QUOTE) begin
        state_next.quoted         = 1'b1;
        state_next.prev_backslash = 1'b0;
      end else if (data_byte == CH_OPEN) begin
        if (depth_full) begin
          state_next       = cleared;
          result.in_object = 1'b0;
          result.dropped   = 1'b1;
        end else begin
          state_next.brace_depth = state.brace_depth + DEPTH_BITS'(1);
        end
      end else if (data_byte == CH_CLOSE) begin
        state_next.brace_depth = depth_dec;
        if (depth_dec == '0) begin
          state_next        = cleared;
          result.object_end = 1'b1;
        end
      end
    end

    result.nest_level = NEST_W'(state_next.brace_depth);
  end

endmodule

/* sv/json_object_stream_framer.sv */
// top level of the json object stream framer: state, result registers, apb register
// depends on jsof_pkg and jsof_step
//
// Usage:
//   s_tdata carries one stream byte per request; every accepted byte yields exactly
//   one result on the master side, in order. Each result is registered when its byte is
//   accepted, and the block takes one byte per cycle while the skid register is empty;
//   the per-byte update is a single pass through jsof_step between the frame state
//   registers and the result register.
//   m_tdata holds the byte and the brace depth after it, m_tlast marks the closing
//   brace of an object, m_tuser flags object membership, the opening brace and a drop
//   of a partial object (pending limit or depth overflow).
//   When the receiver stalls, one more result is held in a skid register, so a byte
//   offered in the stall cycle is still taken; s_tready falls only while the skid
//   register is full, and rises again the cycle after the receiver takes a result.
//   Reset clears the framer to idle, empties both result registers and loads
//   max_pending with 1536. max_pending (paddr 0) is to be written over apb only while
//   the stream is idle; the block itself does not enforce this. pready is always high.
module json_object_stream_framer
  import jsof_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // apb register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // byte input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] data_byte
  // framed output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,   // [7:0] byte_out, [15:8] nest_level
  output logic                  m_tlast,   // object_end
  output logic [2:0]            m_tuser    // [0] in_object, [1] object_start, [2] dropped
);

  logic [MAXP_W-1:0] max_pending;
  frame_state_t      state;
  frame_state_t      state_next;
  frame_result_t     step_result;
  frame_result_t     out_res;
  frame_result_t     skid_res;
  logic              out_valid;
  logic              skid_valid;
  logic              s_fire;
  logic              out_take;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MAX_PENDING);
  assign prdata    = (paddr[2] == REG_MAX_PENDING) ? APB_DATA_W'(max_pending) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_pending <= MAX_PENDING_RESET;
    end else if (cfg_write) begin
      max_pending <= pwdata[MAXP_W-1:0];
    end
  end

  jsof_step u_step (
    .state       (state),
    .data_byte   (s_tdata),
    .max_pending (max_pending),
    .state_next  (state_next),
    .result      (step_result)
  );

  assign s_tready = !skid_valid;
  assign s_fire   = s_tvalid && s_tready;
  assign out_take = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s_fire) begin
      state <= state_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= s_fire;
      end
    end else if (s_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (s_fire) begin
        out_res <= step_result;
      end
    end else if (s_fire) begin
      skid_res <= step_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.nest_level, out_res.byte_out};
  assign m_tlast  = out_res.object_end;
  assign m_tuser  = {out_res.dropped, out_res.object_start, out_res.in_object};

  // the skid entry only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid while output register empty");

  // an idle framer sits at depth zero outside any string
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !state.active |-> (state.brace_depth == '0) && !state.quoted && !state.prev_backslash)
    else $error("idle framer holds stale parse state");

  // a drop leaves nothing of the object in the result
  a_drop_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.dropped) |->
      !out_res.in_object && !out_res.object_end && (out_res.nest_level == '0))
    else $error("dropped byte reported as part of an object");

  // an object end returns the framer to idle
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    (s_fire && step_result.object_end) |=> !state.active && (state.pending_count == '0))
    else $error("framer still active after object end");

endmodule

/* tb/tb_top.sv */
// self-checking testbench for json_object_stream_framer: byte stream in, framed results out
// predicts each result from its own copy of the framing state; depends on jsof_pkg and the rtl
module tb_top;
  import jsof_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [APB_ADDR_W-1:0] MAX_PENDING_ADDR = {REG_MAX_PENDING, 2'b00};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;   // [7:0] data_byte
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [15:0]           m_tdata;        // [7:0] byte_out, [15:8] nest_level
  logic                  m_tlast;        // object_end
  logic [2:0]            m_tuser;        // [0] in_object, [1] object_start, [2] dropped

  // predictor copy of the framer
  logic [MAXP_W-1:0]     pending_limit = MAX_PENDING_RESET;
  logic                  fr_active;
  logic [DEPTH_BITS-1:0] fr_depth;
  logic                  fr_quoted;
  logic                  fr_escape;
  logic [COUNT_BITS-1:0] fr_pending;

  frame_result_t framed_q[$];
  int  fail_count = 0;
  int  bytes_sent = 0;
  int  results_seen = 0;
  int  objects_seen = 0;
  int  drops_seen = 0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  int  calm_left = 0;
  bit  idling_on = 1'b1;

  json_object_stream_framer DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void clear_framing();
    fr_active  = 1'b0;
    fr_depth   = '0;
    fr_quoted  = 1'b0;
    fr_escape  = 1'b0;
    fr_pending = '0;
  endfunction

  // advances the framing state by one byte and returns the result it yields
  function automatic frame_result_t frame_byte(input logic [7:0] b);
    frame_result_t r;
    int unsigned nxt;
    r = '0;
    r.byte_out = b;
    nxt = fr_pending;
    nxt = nxt + 1;
    if (nxt > pending_limit || nxt > (1 << COUNT_BITS) - 1) begin
      clear_framing();
      r.dropped = 1'b1;
    end else if (!fr_active) begin
      fr_pending = COUNT_BITS'(nxt);
      if (b == CH_OPEN) begin
        fr_active = 1'b1;
        fr_depth = DEPTH_BITS'(1);
        fr_quoted = 1'b0;
        fr_escape = 1'b0;
        r.in_object = 1'b1;
        r.object_start = 1'b1;
      end
    end else begin
      fr_pending = COUNT_BITS'(nxt);
      r.in_object = 1'b1;
      if (fr_quoted) begin
        if (fr_escape) fr_escape = 1'b0;
        else if (b == CH_BSLASH) fr_escape = 1'b1;
        else if (b == CH_QUOTE) fr_quoted = 1'b0;
      end else if (b == CH_QUOTE) begin
        fr_quoted = 1'b1;
        fr_escape = 1'b0;
      end else if (b == CH_OPEN) begin
        if (fr_depth == '1) begin
          // depth saturated: the partial object goes away
          clear_framing();
          r.in_object = 1'b0;
          r.dropped = 1'b1;
        end else begin
          fr_depth = fr_depth + 1'b1;
        end
      end else if (b == CH_CLOSE) begin
        fr_depth = fr_depth - 1'b1;
        if (fr_depth == '0) begin
          r.object_end = 1'b1;
          clear_framing();
        end
      end
    end
    r.nest_level = NEST_W'(fr_depth);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // one request on the byte stream, with an occasional sender gap in front
  task automatic push_byte(input logic [7:0] b);
    int gap;
    if (idling_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 17);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    framed_q.push_back(frame_byte(b));
    bytes_sent++;
  endtask

  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    while (framed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_max_pending_readback();
    psel <= 1'b1;
    pwrite <= 1'b0;
    paddr <= MAX_PENDING_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== APB_DATA_W'(pending_limit))
      report_mismatch($sformatf("max_pending read %0d, want %0d", prdata, pending_limit));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_max_pending(input int unsigned v);
    wait_results_done();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MAX_PENDING_ADDR;
    pwdata <= APB_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pending_limit = MAXP_W'(v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    check_max_pending_readback();
  endtask

  // a brace-balanced object with random content; incomplete ones stop early
  task automatic send_json_object(input int body_len, input bit complete);
    int depth;
    int r;
    bit in_str;
    push_byte(CH_OPEN);
    depth = 1;
    in_str = 1'b0;
    for (int k = 0; k < body_len; k++) begin
      if (in_str) begin
        r = $urandom_range(0, 255);
        push_byte(8'(r));
        if (r == CH_QUOTE) in_str = 1'b0;
        else if (r == CH_BSLASH) push_byte(8'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 9))
          0, 1: begin
            push_byte(CH_QUOTE);
            in_str = 1'b1;
          end
          2: begin
            push_byte(CH_OPEN);
            depth++;
          end
          3: begin
            if (depth > 1) begin
              push_byte(CH_CLOSE);
              depth--;
            end
          end
          4: push_byte(CH_BSLASH);
          default: push_byte(8'($urandom_range(8'h30, 8'h5A)));
        endcase
      end
    end
    if (complete) begin
      if (in_str) push_byte(CH_QUOTE);
      while (depth > 0) begin
        push_byte(CH_CLOSE);
        depth--;
      end
    end
  endtask

  task automatic test_reset_value();
    check_max_pending_readback();
  endtask

  task automatic test_idle_bytes();
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CH_CLOSE);
    push_byte(CH_QUOTE);
    push_byte(CH_BSLASH);
    push_byte(8'hAA);
    push_byte(8'h55);
  endtask

  task automatic test_escapes_and_nesting();
    push_byte(CH_OPEN);
    push_byte(CH_QUOTE);
    push_byte(CH_BSLASH);
    push_byte(CH_QUOTE);   // escaped quote stays in the string
    push_byte(CH_CLOSE);   // brace inside a string
    push_byte(CH_BSLASH);
    push_byte(CH_BSLASH);  // escaped backslash does not escape the quote
    push_byte(CH_QUOTE);
    push_byte(CH_BSLASH);  // backslash outside a string
    push_byte(CH_OPEN);
    push_byte(CH_CLOSE);
    push_byte(CH_CLOSE);
  endtask

  task automatic test_depth_overflow();
    repeat ((1 << DEPTH_BITS)) push_byte(CH_OPEN);
    push_byte(CH_CLOSE);
  endtask

  task automatic test_pending_limit();
    program_max_pending(3);
    push_byte(CH_OPEN);
    push_byte(8'h61);
    push_byte(8'h62);
    push_byte(8'h63);      // the byte before this one was past the limit
    push_byte(CH_OPEN);
    push_byte(CH_CLOSE);
    program_max_pending(1);
    push_byte(8'h78);
    push_byte(CH_OPEN);
    push_byte(CH_OPEN);
    program_max_pending(0);
    push_byte(CH_OPEN);
    push_byte(8'h71);
    program_max_pending((1 << MAXP_W) - 1);
  endtask

  task automatic test_random_traffic(input int n_bytes);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
        1: send_json_object($urandom_range(0, 12), 1'b0);
        default: begin
          if ($urandom_range(0, 19) == 0) send_json_object($urandom_range(60, 150), 1'b1);
          else send_json_object($urandom_range(0, 30), 1'b1);
        end
      endcase
    end
  endtask

  // receiver side: stall bursts with calm stretches between them
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (calm_left > 0) begin
      calm_left <= calm_left - 1;
      m_tready <= 1'b1;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 16);
      m_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 15) == 0) calm_left <= $urandom_range(10, 60);
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.byte_out     = m_tdata[7:0];
      got.nest_level   = m_tdata[15:8];
      got.object_end   = m_tlast;
      got.in_object    = m_tuser[0];
      got.object_start = m_tuser[1];
      got.dropped      = m_tuser[2];
      results_seen++;
      if (got.object_end) objects_seen++;
      if (got.dropped) drops_seen++;
      if (framed_q.size() == 0) begin
        report_mismatch($sformatf("result for byte %0h with none pending", got.byte_out));
      end else begin
        want = framed_q.pop_front();
        if (got.byte_out !== want.byte_out)
          report_mismatch($sformatf("byte_out %0h, want %0h", got.byte_out, want.byte_out));
        if (got.in_object !== want.in_object)
          report_mismatch($sformatf("in_object %0b, want %0b (byte %0h)",
                                    got.in_object, want.in_object, want.byte_out));
        if (got.object_start !== want.object_start)
          report_mismatch($sformatf("object_start %0b, want %0b (byte %0h)",
                                    got.object_start, want.object_start, want.byte_out));
        if (got.object_end !== want.object_end)
          report_mismatch($sformatf("object_end %0b, want %0b (byte %0h)",
                                    got.object_end, want.object_end, want.byte_out));
        if (got.nest_level !== want.nest_level)
          report_mismatch($sformatf("nest_level %0d, want %0d (byte %0h)",
                                    got.nest_level, want.nest_level, want.byte_out));
        if (got.dropped !== want.dropped)
          report_mismatch($sformatf("dropped %0b, want %0b (byte %0h)",
                                    got.dropped, want.dropped, want.byte_out));
      end
    end
  end

  // watchdog on cycles where neither side nor the register port moves
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without progress", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    clear_framing();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_value();
    test_idle_bytes();
    test_escapes_and_nesting();
    test_depth_overflow();
    test_pending_limit();
    test_random_traffic(220);
    program_max_pending(MAX_PENDING_RESET);
    test_random_traffic(220);
    program_max_pending($urandom_range(16, 64));
    test_random_traffic(160);
    program_max_pending($urandom_range(1, 8));
    test_random_traffic(80);
    program_max_pending(MAX_PENDING_RESET);
    idling_on = 1'b0;
    test_random_traffic(160);
    wait_results_done();
    $display("framer run: %0d bytes sent, %0d results checked, %0d objects closed, %0d drops",
             bytes_sent, results_seen, objects_seen, drops_seen);
    $display("max_pending settings: reset value, 0, 1, 3, small random ones and 4095");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
